FILE: rtl/core/complex_decimating_fir_defines.svh
// ---------------------------------------------------------------------------
// complex decimating fir assertion macros
// shared property wrappers, clocked on clock and disabled during reset
// ---------------------------------------------------------------------------
`ifndef COMPLEX_DECIMATING_FIR_DEFINES_SVH
`define COMPLEX_DECIMATING_FIR_DEFINES_SVH

// same-cycle implication
`define CFIR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/cfir_pkg.sv
// ---------------------------------------------------------------------------
// cfir_pkg
// types and fixed constants of the complex decimating fir
// ---------------------------------------------------------------------------
package cfir_pkg;

   // request kinds
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_COEF   = 1'b1
   } command_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } fsm_state_type;

   // per-cell control
   typedef struct packed {
      logic shift_en;
      logic coef_we;
   } cell_ctrl_type;

   localparam int COEF_INDEX_W = 5;
   localparam int FACTOR_W     = 7;
   localparam int PHASE_W      = 6;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 2;

   localparam logic [FACTOR_W-1:0]   MAX_FACTOR      = 7'd64;
   localparam logic [FACTOR_W-1:0]   RESET_FACTOR    = 7'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FACTOR_ADDR = 2'd0;

endpackage

FILE: rtl/core/cfir_req_if.sv
// ---------------------------------------------------------------------------
// cfir_req_if
// request channel: complex sample or coefficient write, valid/ready
// ---------------------------------------------------------------------------
interface cfir_req_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
);
   import cfir_pkg::*;

   logic                                valid;
   logic                                ready;
   command_type                         command;
   logic signed [SAMPLE_BITS-1:0]       sample_re;
   logic signed [SAMPLE_BITS-1:0]       sample_im;
   logic        [COEF_INDEX_W-1:0]      coef_index;
   logic signed [COEF_BITS-1:0]         coef_value;

   modport source (
      output valid, command, sample_re, sample_im, coef_index, coef_value,
      input  ready
   );

   modport sink (
      input  valid, command, sample_re, sample_im, coef_index, coef_value,
      output ready
   );

endinterface

FILE: rtl/core/cfir_rsp_if.sv
// ---------------------------------------------------------------------------
// cfir_rsp_if
// result channel: filtered complex output, valid/ready
// ---------------------------------------------------------------------------
interface cfir_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_re;
   logic signed [SAMPLE_BITS-1:0] out_im;

   modport source (
      output valid, out_re, out_im,
      input  ready
   );

   modport sink (
      input  valid, out_re, out_im,
      output ready
   );

endinterface

FILE: rtl/core/cfir_tap_cell.sv
// ---------------------------------------------------------------------------
// cfir_tap_cell
// one tap: delay-line stage, coefficient, registered products and a
// partial-sum stage that adds its products to the sum from its neighbor
// ---------------------------------------------------------------------------
module cfir_tap_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16,
   parameter int ACC_W       = 37
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfir_pkg::cell_ctrl_type       ctrl,
   input  logic signed [COEF_BITS-1:0]   coef_value,
   input  logic signed [SAMPLE_BITS-1:0] up_sample_re,
   input  logic signed [SAMPLE_BITS-1:0] up_sample_im,
   input  logic signed [ACC_W-1:0]       up_sum_re,
   input  logic signed [ACC_W-1:0]       up_sum_im,
   output logic signed [SAMPLE_BITS-1:0] dn_sample_re,
   output logic signed [SAMPLE_BITS-1:0] dn_sample_im,
   output logic signed [ACC_W-1:0]       dn_sum_re,
   output logic signed [ACC_W-1:0]       dn_sum_im
);
   import cfir_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;

   logic signed [SAMPLE_BITS-1:0] sample_re_ff, sample_re_in;
   logic signed [SAMPLE_BITS-1:0] sample_im_ff, sample_im_in;
   logic signed [COEF_BITS-1:0]   coef_ff, coef_in;
   logic signed [PROD_W-1:0]      prod_re_ff, prod_re_in;
   logic signed [PROD_W-1:0]      prod_im_ff, prod_im_in;
   logic signed [ACC_W-1:0]       sum_re_ff, sum_re_in;
   logic signed [ACC_W-1:0]       sum_im_ff, sum_im_in;

   // delay line shift and coefficient load
   always_comb begin
      sample_re_in = ctrl.shift_en ? up_sample_re : sample_re_ff;
      sample_im_in = ctrl.shift_en ? up_sample_im : sample_im_ff;
      coef_in      = ctrl.coef_we  ? coef_value   : coef_ff;
   end

   // products, then partial sum from the neighbor
   always_comb begin
      prod_re_in = sample_re_ff * coef_ff;
      prod_im_in = sample_im_ff * coef_ff;
      sum_re_in  = up_sum_re + {{(ACC_W-PROD_W){prod_re_ff[PROD_W-1]}}, prod_re_ff};
      sum_im_in  = up_sum_im + {{(ACC_W-PROD_W){prod_im_ff[PROD_W-1]}}, prod_im_ff};
   end

   // filter state, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_re_ff <= '0;
         sample_im_ff <= '0;
         coef_ff      <= '0;
      end else begin
         sample_re_ff <= sample_re_in;
         sample_im_ff <= sample_im_in;
         coef_ff      <= coef_in;
      end
   end

   // arithmetic pipeline
   always_ff @(posedge clock) begin
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      sum_re_ff  <= sum_re_in;
      sum_im_ff  <= sum_im_in;
   end

   assign dn_sample_re = sample_re_ff;
   assign dn_sample_im = sample_im_ff;
   assign dn_sum_re    = sum_re_ff;
   assign dn_sum_im    = sum_im_ff;

endmodule

FILE: rtl/core/cfir_round_sat.sv
// ---------------------------------------------------------------------------
// cfir_round_sat
// drops the coefficient fraction with round half up and clamps to the
// sample range
// ---------------------------------------------------------------------------
module cfir_round_sat #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16,
   parameter int ACC_W       = 37
) (
   input  logic signed [ACC_W-1:0]       acc,
   output logic signed [SAMPLE_BITS-1:0] result
);
   localparam int SHIFT = COEF_BITS - 1;
   localparam int EXT_W = ACC_W + 1;
   localparam logic signed [EXT_W-1:0] ROUND_BIAS = EXT_W'(2 ** (SHIFT - 1));
   localparam logic signed [EXT_W-1:0] SAT_HI     = EXT_W'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [EXT_W-1:0] SAT_LO     = EXT_W'(-(2 ** (SAMPLE_BITS - 1)));

   logic signed [EXT_W-1:0] biased;
   logic signed [EXT_W-1:0] shifted;

   // round half up, floor shift, clamp
   always_comb begin
      biased  = {acc[ACC_W-1], acc} + ROUND_BIAS;
      shifted = biased >>> SHIFT;
      if (shifted > SAT_HI) begin
         result = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         result = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         result = shifted[SAMPLE_BITS-1:0];
      end
   end

endmodule

FILE: rtl/core/complex_decimating_fir.sv
// ---------------------------------------------------------------------------
// complex_decimating_fir
// Complex decimating FIR with real coefficients. Samples shift into a row
// of TAPS cells, cell i holding the sample i steps old and coefficient i.
// Coefficient writes and samples that give no output leave the block ready
// for the next request. The sample that completes a decimation period
// starts a summing pass: the partial sums ripple down the cell row one
// cell per cycle behind a product register, then the rounded sums load
// the output register once it has drained; only then is the next request
// taken. Reset clears the delay line and the coefficients at once; no
// clearing pass is needed.
// ---------------------------------------------------------------------------
`include "complex_decimating_fir_defines.svh"

module complex_decimating_fir #(
   parameter int TAPS        = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   cfir_req_if.sink                          req_bus,
   cfir_rsp_if.source                        rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cfir_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cfir_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [cfir_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import cfir_pkg::*;

   localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(TAPS);
   localparam int CNT_W = $clog2(TAPS + 1);

   fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [FACTOR_W-1:0] factor_eff;
   logic [FACTOR_W-1:0] phase_next;
   logic                emit;
   logic                req_fire;
   logic                sample_fire;
   logic                coef_fire;
   logic                csr_write;
   logic                out_free;
   logic                load_rsp;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_re_ff, rsp_re_in;
   logic signed [SAMPLE_BITS-1:0] rsp_im_ff, rsp_im_in;
   logic signed [SAMPLE_BITS-1:0] round_re;
   logic signed [SAMPLE_BITS-1:0] round_im;

   cell_ctrl_type                 cell_ctrl [TAPS];
   logic signed [SAMPLE_BITS-1:0] chain_re  [TAPS+1];
   logic signed [SAMPLE_BITS-1:0] chain_im  [TAPS+1];
   logic signed [ACC_W-1:0]       sum_re    [TAPS+1];
   logic signed [ACC_W-1:0]       sum_im    [TAPS+1];

   // register port
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_comb begin
      factor_in = factor_ff;
      if (csr_write && (paddr == CSR_FACTOR_ADDR)) begin
         factor_in = pwdata[FACTOR_W-1:0];
      end
      prdata = '0;
      if (paddr == CSR_FACTOR_ADDR) begin
         prdata = {{(CSR_DATA_W-FACTOR_W){1'b0}}, factor_ff};
      end
   end

   // request decode
   assign req_fire    = req_bus.valid & req_bus.ready;
   assign sample_fire = req_fire && (req_bus.command == CMD_SAMPLE);
   assign coef_fire   = req_fire && (req_bus.command == CMD_COEF);

   // decimation phase, factor zero acts as one and is capped at the max
   always_comb begin
      if (factor_ff == '0) begin
         factor_eff = RESET_FACTOR;
      end else if (factor_ff > MAX_FACTOR) begin
         factor_eff = MAX_FACTOR;
      end else begin
         factor_eff = factor_ff;
      end
      phase_next = {1'b0, phase_ff} + 1'b1;
      emit       = (phase_next >= factor_eff);
      phase_in   = phase_ff;
      if (sample_fire) begin
         phase_in = emit ? '0 : phase_next[PHASE_W-1:0];
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_fire && emit) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (count_ff == CNT_W'(TAPS)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      load_rsp      = 1'b0;
      count_in      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_RUN: begin
            count_in = count_ff + 1'b1;
         end
         ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   // cell row
   assign chain_re[0] = req_bus.sample_re;
   assign chain_im[0] = req_bus.sample_im;
   assign sum_re[0]   = '0;
   assign sum_im[0]   = '0;

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      assign cell_ctrl[i].shift_en = sample_fire;
      assign cell_ctrl[i].coef_we  = coef_fire && (int'(req_bus.coef_index) == i);

      cfir_tap_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .COEF_BITS   (COEF_BITS),
         .ACC_W       (ACC_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl[i]),
         .coef_value   (req_bus.coef_value),
         .up_sample_re (chain_re[i]),
         .up_sample_im (chain_im[i]),
         .up_sum_re    (sum_re[i]),
         .up_sum_im    (sum_im[i]),
         .dn_sample_re (chain_re[i+1]),
         .dn_sample_im (chain_im[i+1]),
         .dn_sum_re    (sum_re[i+1]),
         .dn_sum_im    (sum_im[i+1])
      );
   end

   // rounding of the finished sums
   cfir_round_sat #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ACC_W       (ACC_W)
   ) u_round_re (
      .acc    (sum_re[TAPS]),
      .result (round_re)
   );

   cfir_round_sat #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ACC_W       (ACC_W)
   ) u_round_im (
      .acc    (sum_im[TAPS]),
      .result (round_im)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_re_in    = round_re;
         rsp_im_in    = round_im;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.out_re = rsp_re_ff;
   assign rsp_bus.out_im = rsp_im_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         phase_ff     <= '0;
         factor_ff    <= RESET_FACTOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         factor_ff    <= factor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_re_ff <= rsp_re_in;
      rsp_im_ff <= rsp_im_in;
   end

   // checks
   `CFIR_ASSERT_NEXT(a_pass_start, sample_fire && emit, (state_ff == ST_RUN) && (count_ff == '0), "period-ending sample did not start a summing pass")
   `CFIR_ASSERT_NOW(a_count_bound, state_ff == ST_RUN, count_ff <= CNT_W'(TAPS), "summing pass ran past the cell row")
   `CFIR_ASSERT_NEXT(a_line_frozen, state_ff != ST_IDLE, $stable(chain_re[1]) && $stable(chain_im[1]), "delay line moved during a summing pass")
   `CFIR_ASSERT_NEXT(a_result_load, (state_ff == ST_DONE) && out_free, rsp_valid_ff, "finished pass did not present a result")

endmodule
